@@ hdl/csw_pkg.sv @@
// Shared types, codes and the helper function of the counting semaphore wait queue.
package csw_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;

    localparam int COUNT_W = 16;
    localparam int INIT_W  = 10;
    localparam int TID_W   = 8;
    localparam int AMT_W   = 6;
    localparam int KIND_W  = 3;
    localparam int RELC_W  = 5;

    localparam logic [KIND_W-1:0] KIND_GRANTED     = 3'd0;
    localparam logic [KIND_W-1:0] KIND_BLOCKED     = 3'd1;
    localparam logic [KIND_W-1:0] KIND_RELEASED    = 3'd2;
    localparam logic [KIND_W-1:0] KIND_SIGNAL_DONE = 3'd3;
    localparam logic [KIND_W-1:0] KIND_REJECTED    = 3'd4;

    localparam logic [1:0] OP_WAIT      = 2'd0;
    localparam logic [1:0] OP_SIG_NEG   = 2'd1;
    localparam logic [1:0] OP_SIG_ONE   = 2'd2;
    localparam logic [1:0] OP_SIG_MULTI = 2'd3;

    localparam logic CMD_WAIT = 1'b0;

    localparam logic signed [AMT_W-1:0] DEC_ONE = -6'sd1;
    localparam logic signed [AMT_W-1:0] INC_ONE = 6'sd1;

    typedef struct packed {
        logic [1:0]                code;
        logic [TID_W-1:0]          tid;
        logic signed [AMT_W-1:0]   amount;
    } csw_op_t;

    // Adds a small signed delta to the count and clamps at the 16-bit signed range.
    function automatic logic signed [COUNT_W-1:0] sat_add(
        input logic signed [COUNT_W-1:0] a,
        input logic signed [AMT_W-1:0]   d
    );
        logic signed [COUNT_W:0] s;
        s = {a[COUNT_W-1], a} + {{(COUNT_W-AMT_W+1){d[AMT_W-1]}}, d};
        if (s[COUNT_W] != s[COUNT_W-1])
        begin
            return s[COUNT_W] ? {1'b1, {(COUNT_W-1){1'b0}}} : {1'b0, {(COUNT_W-1){1'b1}}};
        end
        return s[COUNT_W-1:0];
    endfunction

endpackage

@@ hdl/csw_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
module csw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ hdl/csw_front.sv @@
// Front end: accepts requests, classifies them and holds them in a two-entry queue.
module csw_front (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            cmd,
    input  logic [csw_pkg::TID_W-1:0]       thread_id,
    input  logic signed [csw_pkg::AMT_W-1:0] signal_count,
    output logic                            op_valid,
    input  logic                            op_pop,
    output csw_pkg::csw_op_t                op
);
    import csw_pkg::*;

    csw_op_t    entry_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] fill_reg;
    logic [1:0] fill_next;
    logic       push;
    logic       pop;
    csw_op_t    decoded;

    always_comb
    begin
        decoded.tid    = thread_id;
        decoded.amount = signal_count;
        priority if (cmd == CMD_WAIT)
        begin
            decoded.code = OP_WAIT;
        end
        else if (signal_count[AMT_W-1])
        begin
            decoded.code = OP_SIG_NEG;
        end
        else if (signal_count == '0)
        begin
            decoded.code = OP_SIG_ONE;
        end
        else
        begin
            decoded.code = OP_SIG_MULTI;
        end
    end

    assign in_stall = (fill_reg == 2'd2);
    assign push     = in_valid && !in_stall;
    assign op_valid = (fill_reg != 2'd0);
    assign pop      = op_pop && op_valid;
    assign op       = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= decoded;
        end
    end

endmodule

@@ hdl/csw_back.sv @@
// Back end: semaphore count, wait queue storage and the result register.
module csw_back #(
    parameter int QUEUE_DEPTH = csw_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [csw_pkg::INIT_W-1:0]       cfg_wr_data,
    input  logic                             op_valid,
    output logic                             op_pop,
    input  csw_pkg::csw_op_t                 op,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [csw_pkg::KIND_W-1:0]       kind,
    output logic [csw_pkg::TID_W-1:0]        released_id,
    output logic signed [csw_pkg::AMT_W-1:0] return_value,
    output logic                             last
);
    import csw_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int LW = $clog2(QUEUE_DEPTH + 1);
    localparam int CW = (LW > RELC_W) ? LW : RELC_W;
    localparam logic [AW-1:0] LAST_SLOT = AW'(QUEUE_DEPTH - 1);
    localparam logic [LW-1:0] FULL_LEN  = LW'(QUEUE_DEPTH);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_REL  = 1'b1;

    logic                       state_reg, state_next;
    logic signed [COUNT_W-1:0]  count_reg, count_next;
    logic [AW-1:0]              head_reg, head_next;
    logic [AW-1:0]              tail_reg, tail_next;
    logic [LW-1:0]              len_reg, len_next;
    logic [RELC_W-1:0]          rel_left_reg, rel_left_next;
    logic signed [AMT_W-1:0]    rel_rv_reg, rel_rv_next;

    logic                       out_valid_reg, out_valid_next;
    logic [KIND_W-1:0]          kind_reg, kind_next;
    logic [TID_W-1:0]           id_reg, id_next;
    logic signed [AMT_W-1:0]    rv_reg, rv_next;
    logic                       last_reg, last_next;
    logic                       out_load;

    logic                       out_free;
    logic                       ram_we;
    logic                       ram_re;
    logic [TID_W-1:0]           ram_rdata;
    logic [AW-1:0]              head_inc;
    logic [AW-1:0]              tail_inc;
    logic [CW-1:0]              len_w;
    logic [CW-1:0]              amt_w;
    logic [RELC_W-1:0]          rel_cnt;

    assign out_free = !out_valid_reg || !out_stall;
    assign head_inc = (head_reg == LAST_SLOT) ? '0 : head_reg + AW'(1);
    assign tail_inc = (tail_reg == LAST_SLOT) ? '0 : tail_reg + AW'(1);
    assign len_w    = CW'(len_reg);
    assign amt_w    = CW'(op.amount[RELC_W-1:0]);
    assign rel_cnt  = (len_w < amt_w) ? len_w[RELC_W-1:0] : op.amount[RELC_W-1:0];

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        len_next      = len_reg;
        rel_left_next = rel_left_reg;
        rel_rv_next   = rel_rv_reg;
        kind_next     = kind_reg;
        id_next       = id_reg;
        rv_next       = rv_reg;
        last_next     = last_reg;
        out_load      = 1'b0;
        ram_we        = 1'b0;
        ram_re        = 1'b0;
        op_pop        = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (op_valid && out_free)
                begin
                    op_pop = 1'b1;
                    unique case (op.code)
                        OP_WAIT:
                        begin
                            out_load  = 1'b1;
                            id_next   = op.tid;
                            rv_next   = '0;
                            last_next = 1'b1;
                            priority if (count_reg > 0)
                            begin
                                count_next = sat_add(count_reg, DEC_ONE);
                                kind_next  = KIND_GRANTED;
                                rv_next    = INC_ONE;
                            end
                            else if (len_reg == FULL_LEN)
                            begin
                                kind_next = KIND_REJECTED;
                            end
                            else
                            begin
                                count_next = sat_add(count_reg, DEC_ONE);
                                ram_we     = 1'b1;
                                tail_next  = tail_inc;
                                len_next   = len_reg + LW'(1);
                                kind_next  = KIND_BLOCKED;
                            end
                        end
                        OP_SIG_NEG:
                        begin
                            out_load  = 1'b1;
                            kind_next = KIND_SIGNAL_DONE;
                            id_next   = '0;
                            rv_next   = op.amount;
                            last_next = 1'b1;
                        end
                        OP_SIG_ONE:
                        begin
                            count_next = sat_add(count_reg, INC_ONE);
                            if (count_reg[COUNT_W-1] && (len_reg != '0))
                            begin
                                ram_re        = 1'b1;
                                head_next     = head_inc;
                                len_next      = len_reg - LW'(1);
                                rel_left_next = '0;
                                rel_rv_next   = '0;
                                state_next    = ST_REL;
                            end
                            else
                            begin
                                out_load  = 1'b1;
                                kind_next = KIND_SIGNAL_DONE;
                                id_next   = '0;
                                rv_next   = '0;
                                last_next = 1'b1;
                            end
                        end
                        OP_SIG_MULTI:
                        begin
                            count_next = sat_add(count_reg, op.amount);
                            if (len_reg != '0)
                            begin
                                ram_re        = 1'b1;
                                head_next     = head_inc;
                                len_next      = len_reg - LW'(1);
                                rel_left_next = rel_cnt - RELC_W'(1);
                                rel_rv_next   = AMT_W'(rel_cnt);
                                state_next    = ST_REL;
                            end
                            else
                            begin
                                out_load  = 1'b1;
                                kind_next = KIND_SIGNAL_DONE;
                                id_next   = '0;
                                rv_next   = '0;
                                last_next = 1'b1;
                            end
                        end
                    endcase
                end
            end
            ST_REL:
            begin
                if (out_free)
                begin
                    out_load  = 1'b1;
                    kind_next = KIND_RELEASED;
                    id_next   = ram_rdata;
                    rv_next   = rel_rv_reg;
                    last_next = (rel_left_reg == '0);
                    if (rel_left_reg != '0)
                    begin
                        ram_re        = 1'b1;
                        head_next     = head_inc;
                        len_next      = len_reg - LW'(1);
                        rel_left_next = rel_left_reg - RELC_W'(1);
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
        endcase

        if (cfg_wr_en)
        begin
            count_next = COUNT_W'(cfg_wr_data);
            head_next  = '0;
            tail_next  = '0;
            len_next   = '0;
            state_next = ST_IDLE;
        end

        out_valid_next = out_free ? out_load : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            len_reg       <= '0;
            rel_left_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            len_reg       <= len_next;
            rel_left_reg  <= rel_left_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rel_rv_reg <= rel_rv_next;
        if (out_load && out_free)
        begin
            kind_reg <= kind_next;
            id_reg   <= id_next;
            rv_reg   <= rv_next;
            last_reg <= last_next;
        end
    end

    csw_ram #(
        .WIDTH (TID_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_wait_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (tail_reg),
        .wr_data (op.tid),
        .rd_en   (ram_re),
        .rd_addr (head_reg),
        .rd_data (ram_rdata)
    );

    assign out_valid    = out_valid_reg;
    assign kind         = kind_reg;
    assign released_id  = id_reg;
    assign return_value = rv_reg;
    assign last         = last_reg;

endmodule

@@ hdl/counting_semaphore_wait_queue_top.sv @@
// Top level of the counting semaphore with a FIFO wait queue.
// A request releasing no waiter has its result registered when the back end pops it.
// A releasing request reads each released thread from the wait RAM into the result
// register, one per cycle while unstalled; no new request is taken until the last.
// Other requests go one per cycle unless out_stall holds the single result register.
// Reset clears the count to zero and empties the queue; a register write reloads both.
module counting_semaphore_wait_queue_top #(
    parameter int QUEUE_DEPTH = csw_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [csw_pkg::INIT_W-1:0]       cfg_wr_data,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic                             cmd,
    input  logic [csw_pkg::TID_W-1:0]        thread_id,
    input  logic signed [csw_pkg::AMT_W-1:0] signal_count,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [csw_pkg::KIND_W-1:0]       kind,
    output logic [csw_pkg::TID_W-1:0]        released_id,
    output logic signed [csw_pkg::AMT_W-1:0] return_value,
    output logic                             last
);
    import csw_pkg::*;

    logic    op_valid;
    logic    op_pop;
    csw_op_t op;

    csw_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .cmd          (cmd),
        .thread_id    (thread_id),
        .signal_count (signal_count),
        .op_valid     (op_valid),
        .op_pop       (op_pop),
        .op           (op)
    );

    csw_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .op_valid     (op_valid),
        .op_pop       (op_pop),
        .op           (op),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .kind         (kind),
        .released_id  (released_id),
        .return_value (return_value),
        .last         (last)
    );

    a_granted_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == KIND_GRANTED) |-> (return_value == INC_ONE) && last)
        else $error("Granted wait must return one on a final result.");

    a_done_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == KIND_SIGNAL_DONE) |-> (released_id == '0) && last)
        else $error("Signal without release must carry id zero on a final result.");

    a_blocked_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && ((kind == KIND_BLOCKED) || (kind == KIND_REJECTED))
        |-> (return_value == '0) && last)
        else $error("Blocked or rejected wait must return zero on a final result.");

    a_released_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == KIND_RELEASED) |-> !return_value[AMT_W-1])
        else $error("Release count must not be negative.");

endmodule

@@ bench/counting_semaphore_wait_queue_top_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench of the counting semaphore with a FIFO wait queue.
module counting_semaphore_wait_queue_top_tb;
    import csw_pkg::*;

    localparam int WAIT_DEPTH = QUEUE_DEPTH_DEF;
    localparam logic CMD_SIGNAL = ~CMD_WAIT;
    localparam int COUNT_TOP = 32767;
    localparam int COUNT_BOTTOM = -32768;

    typedef struct {
        logic [KIND_W-1:0]       kind;
        logic [TID_W-1:0]        id;
        logic signed [AMT_W-1:0] retval;
        logic                    last;
    } sem_result_t;

    class semaphore_scoreboard;
        int count;
        logic [TID_W-1:0] waiters[$];
        sem_result_t pending_results[$];
        int errors;

        function void load_initial(logic [INIT_W-1:0] value);
            count = int'(value);
            waiters.delete();
        endfunction

        function int clamp_count(int v);
            if (v > COUNT_TOP)
            begin
                return COUNT_TOP;
            end
            if (v < COUNT_BOTTOM)
            begin
                return COUNT_BOTTOM;
            end
            return v;
        endfunction

        function void push_result(logic [KIND_W-1:0] k, logic [TID_W-1:0] id,
                                  logic signed [AMT_W-1:0] rv, logic fin);
            sem_result_t r;
            r.kind = k;
            r.id = id;
            r.retval = rv;
            r.last = fin;
            pending_results.push_back(r);
        endfunction

        function void note_request(logic c, logic [TID_W-1:0] tid,
                                   logic signed [AMT_W-1:0] n);
            int amount;
            int lowered;
            int releases;
            bit was_negative;
            amount = n;
            if (c == CMD_WAIT)
            begin
                lowered = clamp_count(count - 1);
                if (lowered >= 0)
                begin
                    count = lowered;
                    push_result(KIND_GRANTED, tid, 6'sd1, 1'b1);
                end
                else if (waiters.size() >= WAIT_DEPTH)
                begin
                    push_result(KIND_REJECTED, tid, 6'sd0, 1'b1);
                end
                else
                begin
                    count = lowered;
                    waiters.push_back(tid);
                    push_result(KIND_BLOCKED, tid, 6'sd0, 1'b1);
                end
            end
            else if (amount < 0)
            begin
                push_result(KIND_SIGNAL_DONE, '0, n, 1'b1);
            end
            else if (amount == 0)
            begin
                was_negative = count < 0;
                count = clamp_count(count + 1);
                if (was_negative && waiters.size() > 0)
                begin
                    push_result(KIND_RELEASED, waiters.pop_front(), 6'sd0, 1'b1);
                end
                else
                begin
                    push_result(KIND_SIGNAL_DONE, '0, 6'sd0, 1'b1);
                end
            end
            else
            begin
                releases = (waiters.size() < amount) ? waiters.size() : amount;
                count = clamp_count(count + amount);
                if (releases == 0)
                begin
                    push_result(KIND_SIGNAL_DONE, '0, 6'sd0, 1'b1);
                end
                for (int i = 0; i < releases; i++)
                begin
                    push_result(KIND_RELEASED, waiters.pop_front(), AMT_W'(releases),
                                i == releases - 1);
                end
            end
        endfunction

        task report_mismatch(string what);
            $display("%0t ns mismatch: %s", $time, what);
            errors++;
        endtask

        task check_result(logic [KIND_W-1:0] k, logic [TID_W-1:0] id,
                          logic signed [AMT_W-1:0] rv, logic fin);
            sem_result_t want;
            if (pending_results.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result kind %0d id %0d", k, id));
            end
            else
            begin
                want = pending_results.pop_front();
                if (k !== want.kind)
                begin
                    report_mismatch($sformatf("kind %0d, wanted %0d", k, want.kind));
                end
                if (id !== want.id)
                begin
                    report_mismatch($sformatf("released_id %0d, wanted %0d", id, want.id));
                end
                if (rv !== want.retval)
                begin
                    report_mismatch($sformatf("return_value %0d, wanted %0d",
                                              rv, want.retval));
                end
                if (fin !== want.last)
                begin
                    report_mismatch($sformatf("last %0b, wanted %0b", fin, want.last));
                end
            end
        endtask
    endclass

    logic                    clk;
    logic                    rst_n;
    logic                    cfg_wr_en;
    logic [INIT_W-1:0]       cfg_wr_data;
    logic                    in_valid;
    logic                    in_stall;
    logic                    cmd;
    logic [TID_W-1:0]        thread_id;
    logic signed [AMT_W-1:0] signal_count;
    logic                    out_valid;
    logic                    out_stall;
    logic [KIND_W-1:0]       kind;
    logic [TID_W-1:0]        released_id;
    logic signed [AMT_W-1:0] return_value;
    logic                    last;

    semaphore_scoreboard sb = new();
    int send_idle_pct = 26;
    int recv_idle_pct = 74;
    int hold_seq = 0;

    counting_semaphore_wait_queue_top #(
        .QUEUE_DEPTH(WAIT_DEPTH)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .cmd(cmd),
        .thread_id(thread_id),
        .signal_count(signal_count),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .kind(kind),
        .released_id(released_id),
        .return_value(return_value),
        .last(last)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #4_000_000;
        $display("counting_semaphore_wait_queue_top_tb NOT OK");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_wr_en)
            begin
                sb.load_initial(cfg_wr_data);
            end
            if (in_valid && !in_stall)
            begin
                sb.note_request(cmd, thread_id, signal_count);
            end
            if (out_valid && !out_stall)
            begin
                sb.check_result(kind, released_id, return_value, last);
            end
        end
    end

    initial
    begin : receiver
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_seq != hold_seen)
            begin
                hold_seen = hold_seq;
                hold_left = 80;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
            end
        end
    end

    task automatic send_request(input logic c, input logic [TID_W-1:0] tid,
                                input logic signed [AMT_W-1:0] n);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        cmd <= c;
        thread_id <= tid;
        signal_count <= n;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (sb.pending_results.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (24) @(negedge clk);
    endtask

    task automatic write_initial(input logic [INIT_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic random_requests(input int total);
        int wait_pct;
        int pick;
        logic c;
        logic signed [AMT_W-1:0] amount;
        wait_pct = 50;
        for (int i = 0; i < total; i++)
        begin
            if (i % 16 == 0)
            begin
                pick = $urandom_range(0, 2);
                wait_pct = (pick == 0) ? 25 : (pick == 1) ? 50 : 85;
            end
            c = ($urandom_range(0, 99) < wait_pct) ? CMD_WAIT : CMD_SIGNAL;
            pick = $urandom_range(0, 99);
            if (pick < 10)
            begin
                amount = AMT_W'(-int'($urandom_range(1, 32)));
            end
            else if (pick < 55)
            begin
                amount = '0;
            end
            else if (pick < 90)
            begin
                amount = AMT_W'($urandom_range(1, 4));
            end
            else
            begin
                amount = AMT_W'($urandom_range(5, 31));
            end
            send_request(c, TID_W'($urandom_range(0, 255)), amount);
        end
    endtask

    initial
    begin : stimulus
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        in_valid = 1'b0;
        cmd = CMD_WAIT;
        thread_id = '0;
        signal_count = '0;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        write_initial('0);
        send_request(CMD_SIGNAL, TID_W'($urandom_range(0, 255)), -6'sd32);
        send_request(CMD_SIGNAL, TID_W'($urandom_range(0, 255)), -6'sd1);
        for (int i = 0; i < WAIT_DEPTH; i++)
        begin
            send_request(CMD_WAIT, TID_W'(i * 17), '0);
        end
        send_request(CMD_WAIT, 8'h7E, '0);
        send_request(CMD_SIGNAL, TID_W'($urandom_range(0, 255)), 6'sd0);
        send_request(CMD_SIGNAL, TID_W'($urandom_range(0, 255)), 6'sd3);
        send_request(CMD_SIGNAL, TID_W'($urandom_range(0, 255)), 6'sd31);
        send_request(CMD_WAIT, 8'h3C, '0);
        send_request(CMD_SIGNAL, TID_W'($urandom_range(0, 255)), 6'sd0);
        send_request(CMD_SIGNAL, TID_W'($urandom_range(0, 255)), 6'sd5);
        wait_drained();

        write_initial(10'd2);
        hold_seq++;
        random_requests(35);
        wait_drained();

        send_idle_pct = 74;
        recv_idle_pct = 26;
        write_initial(INIT_W'($urandom_range(0, 4)));
        random_requests(35);
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_initial(INIT_W'($urandom_range(0, 4)));
        random_requests(35);
        wait_drained();

        if (sb.errors == 0)
        begin
            $display("counting_semaphore_wait_queue_top_tb OK");
        end
        else
        begin
            $display("counting_semaphore_wait_queue_top_tb NOT OK");
        end
        $finish;
    end

endmodule
